### rtl/sparse_row_index_table_macros.svh
// Assertion macros for the sparse row index table checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef SPARSE_ROW_INDEX_TABLE_MACROS_SVH
`define SPARSE_ROW_INDEX_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRI_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sri: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SRI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sri: next-cycle check failed");

`endif

### rtl/sri_pkg.sv
// Shared types and constants of the sparse row index table.
// No dependencies; used by the top level and its checker.
package sri_pkg;

	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLS    = 64;
	localparam int MAX_ENTRIES = 4096;

	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int IDX_W  = $clog2(MAX_ENTRIES);
	localparam int FILL_W = IDX_W + 1;
	localparam int RCNT_W = ROW_W + 1;
	localparam int CCNT_W = COL_W + 1;
	localparam int RS_AW  = $clog2(MAX_ROWS + 1);
	localparam int CFG_W  = 7;

	typedef enum logic [1:0] {
		CMD_LOAD     = 2'd0,
		CMD_LOOKUP   = 2'd1,
		CMD_LIST_ROW = 2'd2,
		CMD_LIST_COL = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_NOT_FOUND  = 2'd1,
		STAT_LOAD_ORDER = 2'd2,
		STAT_INCOMPLETE = 2'd3
	} status_t;

	typedef enum logic {
		REG_NUM_ROWS = 1'b0,
		REG_NUM_COLS = 1'b1
	} reg_index_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [63:0]      row_bits;
	} in_item_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] entry_index;
		logic [5:0]       position;
		logic             last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_LOAD_END,
		ST_RS_LO,
		ST_RS_HI,
		ST_RS_GET,
		ST_BS_CHK,
		ST_BS_CMP,
		ST_COL_PUSH,
		ST_COL_NEXT,
		ST_RL_RD,
		ST_RL_EMIT,
		ST_REPLY
	} state_t;

endpackage

### rtl/sparse_row_index_table.sv
// Sparse row index table: compressed-sparse-row index of a binary mask.
// Depends on sri_pkg for the item structs, codes and state type.
//
// Usage: items arrive on in_valid/in_stall/in_data and results leave on
// out_valid/out_stall/out_data; a transfer happens when valid is high and
// stall is low. One item is worked on at a time: in_stall is high from the
// cycle after a transfer until the item's last result has been handed to the
// output register. The output register lets the next item be taken while the
// last result still waits for the receiver.
// Work per item; searches and lists share the single column-store read port:
//   load:        one mask bit examined per cycle, num_cols bits in all
//   lookup:      row start reads, then a binary search, at most 7 steps for 64 entries
//   row list:    row start reads, then one read per stored entry of the row
//   column list: a binary search of every built row in turn
//   errors, incomplete table, row beyond table: a reply with no search
// A stalled receiver holds the sequencer at its next result; nothing is lost.
// Reset clears the build (no rows loaded, table incomplete) and sets both
// registers to 64; no clearing pass runs and items are taken at once.
// cfg_we writes register cfg_index (0 rows, 1 columns) with cfg_data.
module sparse_row_index_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  sri_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output sri_pkg::out_item_t                out_data,
	input  logic                              cfg_we,
	input  sri_pkg::reg_index_t               cfg_index,
	input  logic [sri_pkg::CFG_W-1:0]         cfg_data
);

	// Configuration and build state
	logic [sri_pkg::CFG_W-1:0]  num_rows_q, num_cols_q;
	logic [sri_pkg::RCNT_W-1:0] rows_eff, cols_eff;
	logic [sri_pkg::FILL_W-1:0] fill_q;
	logic [sri_pkg::RCNT_W-1:0] next_row_q;
	logic                       complete_q;

	// Sequencer
	sri_pkg::state_t state_q, state_d;

	// Captured item
	sri_pkg::cmd_t              cmd_q;
	logic [sri_pkg::ROW_W-1:0]  row_q;
	logic [sri_pkg::COL_W-1:0]  col_q;
	logic [63:0]                bits_q;
	logic [sri_pkg::COL_W-1:0]  j_q;
	logic [sri_pkg::CCNT_W-1:0] cnt_q;

	// Search and list registers
	logic [sri_pkg::FILL_W-1:0] low_q, hi_q;
	logic [sri_pkg::IDX_W-1:0]  mid_q;
	logic [sri_pkg::RCNT_W-1:0] row_i_q;
	logic                       pend_valid_q;
	logic [sri_pkg::IDX_W-1:0]  pend_idx_q;
	logic [sri_pkg::ROW_W-1:0]  pend_pos_q;
	sri_pkg::out_item_t         rep_q;

	// Output register
	logic               out_valid_q;
	sri_pkg::out_item_t out_q;

	// Memories
	logic [sri_pkg::COL_W-1:0]  cs_mem [0:sri_pkg::MAX_ENTRIES-1];
	logic [sri_pkg::FILL_W-1:0] rs_mem [0:sri_pkg::MAX_ROWS];
	logic [sri_pkg::COL_W-1:0]  cs_rdata_q;
	logic [sri_pkg::FILL_W-1:0] rs_rdata_q;
	logic                       cs_we, rs_we;
	logic [sri_pkg::IDX_W-1:0]  cs_waddr, cs_raddr;
	logic [sri_pkg::COL_W-1:0]  cs_wdata;
	logic [sri_pkg::RS_AW-1:0]  rs_waddr, rs_raddr;
	logic [sri_pkg::FILL_W-1:0] rs_wdata;

	// Decoded conditions
	logic                       accept, out_free, emit_valid;
	sri_pkg::out_item_t         emit_data;
	logic [sri_pkg::RCNT_W-1:0] nr_eff, row_ext;
	logic [sri_pkg::FILL_W-1:0] fill_eff;
	logic                       load_bad, row_beyond;
	logic                       j_end, bs_go, bs_less, bs_more, rl_last, rows_left;
	logic                       push_ok;
	logic [sri_pkg::FILL_W:0]   mid_sum;
	logic [sri_pkg::IDX_W-1:0]  mid;
	logic [sri_pkg::RCNT_W-1:0] row_next;

	function automatic sri_pkg::out_item_t miss_result(input sri_pkg::status_t st);
		sri_pkg::out_item_t r;
		r.status      = st;
		r.entry_index = '0;
		r.position    = '0;
		r.last        = 1'b1;
		return r;
	endfunction

	// Clamp registers to their legal range
	always_comb begin
		if (num_rows_q == '0) begin
			rows_eff = sri_pkg::RCNT_W'(1);
		end else if (num_rows_q > sri_pkg::CFG_W'(sri_pkg::MAX_ROWS)) begin
			rows_eff = sri_pkg::RCNT_W'(sri_pkg::MAX_ROWS);
		end else begin
			rows_eff = sri_pkg::RCNT_W'(num_rows_q);
		end
		if (num_cols_q == '0) begin
			cols_eff = sri_pkg::CCNT_W'(1);
		end else if (num_cols_q > sri_pkg::CFG_W'(sri_pkg::MAX_COLS)) begin
			cols_eff = sri_pkg::CCNT_W'(sri_pkg::MAX_COLS);
		end else begin
			cols_eff = sri_pkg::CCNT_W'(num_cols_q);
		end
	end

	assign in_stall  = (state_q != sri_pkg::ST_IDLE);
	assign accept    = in_valid && (state_q == sri_pkg::ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// A load of row 0 restarts the build before the order check
	assign row_ext    = {1'b0, in_data.row};
	assign nr_eff     = (in_data.row == '0) ? '0 : next_row_q;
	assign fill_eff   = (in_data.row == '0) ? '0 : fill_q;
	assign load_bad   = (row_ext != nr_eff) || (nr_eff >= rows_eff);
	assign row_beyond = (row_ext >= next_row_q);

	assign j_end     = ({1'b0, j_q} == (cols_eff - sri_pkg::CCNT_W'(1)));
	assign bs_go     = (low_q < hi_q);
	assign bs_less   = (col_q < cs_rdata_q);
	assign bs_more   = (col_q > cs_rdata_q);
	assign rl_last   = ((low_q + sri_pkg::FILL_W'(1)) == hi_q);
	assign rows_left = (row_i_q < next_row_q);
	assign push_ok   = !pend_valid_q || out_free;
	assign row_next  = {1'b0, row_q} + sri_pkg::RCNT_W'(1);

	// Midpoint of the half-open range [low, hi)
	assign mid_sum = {1'b0, low_q} + {1'b0, hi_q} - (sri_pkg::FILL_W + 1)'(1);
	assign mid     = mid_sum[sri_pkg::IDX_W:1];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sri_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_data.cmd == sri_pkg::CMD_LOAD) begin
						state_d = load_bad ? sri_pkg::ST_REPLY : sri_pkg::ST_LOAD;
					end else if (!complete_q) begin
						state_d = sri_pkg::ST_REPLY;
					end else if (in_data.cmd == sri_pkg::CMD_LIST_COL) begin
						state_d = sri_pkg::ST_COL_NEXT;
					end else if (row_beyond) begin
						state_d = sri_pkg::ST_REPLY;
					end else begin
						state_d = sri_pkg::ST_RS_LO;
					end
				end
			end
			sri_pkg::ST_LOAD: begin
				if (j_end) begin
					state_d = sri_pkg::ST_LOAD_END;
				end
			end
			sri_pkg::ST_LOAD_END: state_d = sri_pkg::ST_REPLY;
			sri_pkg::ST_RS_LO:    state_d = sri_pkg::ST_RS_HI;
			sri_pkg::ST_RS_HI:    state_d = sri_pkg::ST_RS_GET;
			sri_pkg::ST_RS_GET: begin
				state_d = (cmd_q == sri_pkg::CMD_LIST_ROW) ? sri_pkg::ST_RL_RD
					: sri_pkg::ST_BS_CHK;
			end
			sri_pkg::ST_BS_CHK: begin
				if (bs_go) begin
					state_d = sri_pkg::ST_BS_CMP;
				end else begin
					state_d = (cmd_q == sri_pkg::CMD_LIST_COL) ? sri_pkg::ST_COL_NEXT
						: sri_pkg::ST_REPLY;
				end
			end
			sri_pkg::ST_BS_CMP: begin
				if (bs_less || bs_more) begin
					state_d = sri_pkg::ST_BS_CHK;
				end else begin
					state_d = (cmd_q == sri_pkg::CMD_LIST_COL) ? sri_pkg::ST_COL_PUSH
						: sri_pkg::ST_REPLY;
				end
			end
			sri_pkg::ST_COL_PUSH: begin
				if (push_ok) begin
					state_d = sri_pkg::ST_COL_NEXT;
				end
			end
			sri_pkg::ST_COL_NEXT: begin
				state_d = rows_left ? sri_pkg::ST_RS_LO : sri_pkg::ST_REPLY;
			end
			sri_pkg::ST_RL_RD: begin
				state_d = bs_go ? sri_pkg::ST_RL_EMIT : sri_pkg::ST_REPLY;
			end
			sri_pkg::ST_RL_EMIT: begin
				if (out_free) begin
					state_d = rl_last ? sri_pkg::ST_IDLE : sri_pkg::ST_RL_RD;
				end
			end
			sri_pkg::ST_REPLY: begin
				if (out_free) begin
					state_d = sri_pkg::ST_IDLE;
				end
			end
			default: state_d = sri_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: memory ports and result transfer into the output register
	always_comb begin
		emit_valid = 1'b0;
		emit_data  = rep_q;
		cs_we      = 1'b0;
		cs_waddr   = fill_q[sri_pkg::IDX_W-1:0];
		cs_wdata   = j_q;
		cs_raddr   = low_q[sri_pkg::IDX_W-1:0];
		rs_we      = 1'b0;
		rs_waddr   = row_next;
		rs_wdata   = fill_q;
		rs_raddr   = row_i_q;
		unique case (state_q)
			sri_pkg::ST_IDLE: begin
				// Record where the new row starts
				rs_we    = accept && (in_data.cmd == sri_pkg::CMD_LOAD) && !load_bad;
				rs_waddr = row_ext;
				rs_wdata = fill_eff;
			end
			sri_pkg::ST_LOAD: begin
				// Store one column per set bit; drop it once storage is full
				cs_we = bits_q[0] && !fill_q[sri_pkg::IDX_W];
			end
			sri_pkg::ST_LOAD_END: begin
				rs_we = 1'b1;
			end
			sri_pkg::ST_RS_LO: begin
				rs_raddr = row_i_q;
			end
			sri_pkg::ST_RS_HI: begin
				rs_raddr = row_i_q + sri_pkg::RCNT_W'(1);
			end
			sri_pkg::ST_BS_CHK: begin
				cs_raddr = mid;
			end
			sri_pkg::ST_COL_PUSH: begin
				// Release the held hit; it is not the last one
				emit_valid            = out_free && pend_valid_q;
				emit_data.status      = sri_pkg::STAT_OK;
				emit_data.entry_index = pend_idx_q;
				emit_data.position    = pend_pos_q;
				emit_data.last        = 1'b0;
			end
			sri_pkg::ST_RL_EMIT: begin
				emit_valid            = out_free;
				emit_data.status      = sri_pkg::STAT_OK;
				emit_data.entry_index = low_q[sri_pkg::IDX_W-1:0];
				emit_data.position    = cs_rdata_q;
				emit_data.last        = rl_last;
			end
			sri_pkg::ST_REPLY: begin
				emit_valid = out_free;
			end
			default: begin
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sri_pkg::ST_IDLE;
			out_valid_q  <= 1'b0;
			num_rows_q   <= sri_pkg::CFG_W'(sri_pkg::MAX_ROWS);
			num_cols_q   <= sri_pkg::CFG_W'(sri_pkg::MAX_COLS);
			fill_q       <= '0;
			next_row_q   <= '0;
			complete_q   <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Hold the result while stalled, drop it once taken
			if (emit_valid) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					sri_pkg::REG_NUM_ROWS: num_rows_q <= cfg_data;
					sri_pkg::REG_NUM_COLS: num_cols_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (accept) begin
				pend_valid_q <= 1'b0;
				if ((in_data.cmd == sri_pkg::CMD_LOAD) && (in_data.row == '0)) begin
					fill_q     <= '0;
					next_row_q <= '0;
					complete_q <= 1'b0;
				end
			end
			if (cs_we) begin
				fill_q <= fill_q + sri_pkg::FILL_W'(1);
			end
			if (state_q == sri_pkg::ST_LOAD_END) begin
				next_row_q <= row_next;
				// A row count raised after completion leaves the flag set
				if (row_next == rows_eff) begin
					complete_q <= 1'b1;
				end
			end
			if ((state_q == sri_pkg::ST_COL_PUSH) && push_ok) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (emit_valid) begin
			out_q <= emit_data;
		end
		unique case (state_q)
			sri_pkg::ST_IDLE: begin
				if (accept) begin
					cmd_q   <= in_data.cmd;
					row_q   <= in_data.row;
					col_q   <= in_data.col;
					bits_q  <= in_data.row_bits;
					j_q     <= '0;
					cnt_q   <= '0;
					row_i_q <= (in_data.cmd == sri_pkg::CMD_LIST_COL) ? '0 : row_ext;
					if (in_data.cmd == sri_pkg::CMD_LOAD) begin
						rep_q <= miss_result(sri_pkg::STAT_LOAD_ORDER);
					end else if (!complete_q) begin
						rep_q <= miss_result(sri_pkg::STAT_INCOMPLETE);
					end else begin
						rep_q <= miss_result(sri_pkg::STAT_NOT_FOUND);
					end
				end
			end
			sri_pkg::ST_LOAD: begin
				bits_q <= bits_q >> 1;
				j_q    <= j_q + sri_pkg::COL_W'(1);
				if (cs_we) begin
					cnt_q <= cnt_q + sri_pkg::CCNT_W'(1);
				end
			end
			sri_pkg::ST_LOAD_END: begin
				rep_q.status      <= sri_pkg::STAT_OK;
				rep_q.entry_index <= sri_pkg::IDX_W'(cnt_q);
				rep_q.position    <= row_q;
				rep_q.last        <= 1'b1;
			end
			sri_pkg::ST_RS_HI: begin
				low_q <= rs_rdata_q;
			end
			sri_pkg::ST_RS_GET: begin
				hi_q <= rs_rdata_q;
			end
			sri_pkg::ST_BS_CHK: begin
				mid_q <= mid;
				if (!bs_go) begin
					if (cmd_q == sri_pkg::CMD_LIST_COL) begin
						row_i_q <= row_i_q + sri_pkg::RCNT_W'(1);
					end else begin
						rep_q <= miss_result(sri_pkg::STAT_NOT_FOUND);
					end
				end
			end
			sri_pkg::ST_BS_CMP: begin
				if (bs_less) begin
					hi_q <= {1'b0, mid_q};
				end else if (bs_more) begin
					low_q <= {1'b0, mid_q} + sri_pkg::FILL_W'(1);
				end else begin
					rep_q.status      <= sri_pkg::STAT_OK;
					rep_q.entry_index <= mid_q;
					rep_q.position    <= col_q;
					rep_q.last        <= 1'b1;
				end
			end
			sri_pkg::ST_COL_PUSH: begin
				// Hold the newest hit back until it is known whether it ends the list
				if (push_ok) begin
					pend_idx_q <= mid_q;
					pend_pos_q <= row_i_q[sri_pkg::ROW_W-1:0];
					row_i_q    <= row_i_q + sri_pkg::RCNT_W'(1);
				end
			end
			sri_pkg::ST_COL_NEXT: begin
				if (!rows_left) begin
					if (pend_valid_q) begin
						rep_q.status      <= sri_pkg::STAT_OK;
						rep_q.entry_index <= pend_idx_q;
						rep_q.position    <= pend_pos_q;
						rep_q.last        <= 1'b1;
					end else begin
						rep_q <= miss_result(sri_pkg::STAT_NOT_FOUND);
					end
				end
			end
			sri_pkg::ST_RL_RD: begin
				if (!bs_go) begin
					rep_q <= miss_result(sri_pkg::STAT_NOT_FOUND);
				end
			end
			sri_pkg::ST_RL_EMIT: begin
				if (out_free) begin
					low_q <= low_q + sri_pkg::FILL_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Column store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cs_we) begin
			cs_mem[cs_waddr] <= cs_wdata;
		end
		cs_rdata_q <= cs_mem[cs_raddr];
	end

	// Row start offsets: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (rs_we) begin
			rs_mem[rs_waddr] <= rs_wdata;
		end
		rs_rdata_q <= rs_mem[rs_raddr];
	end

endmodule

### rtl/sri_checker.sv
// Port-level checks of the sparse row index table, bound to its top level.
// Depends on sri_pkg and sparse_row_index_table_macros.svh.
`include "sparse_row_index_table_macros.svh"

module sri_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input sri_pkg::out_item_t out_data
);

	// A stalled result stays put
	`SRI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

	// One item at a time: a transfer in closes the input for the next cycle
	`SRI_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall)

	// An idle block with an empty output register does not produce a result
	`SRI_ASSERT_NEXT(a_no_spurious, !in_stall && !out_valid, !out_valid)

	// Error and not-found results carry zero fields and end the item
	`SRI_ASSERT_SAME(a_miss_fields, out_valid && (out_data.status != sri_pkg::STAT_OK), out_data.last && (out_data.entry_index == '0) && (out_data.position == '0))

endmodule

bind sparse_row_index_table sri_checker u_sri_checker (.*);

### verif/tb_top.sv
// Self-checking testbench for the sparse row index table.
// Depends on sri_pkg and sparse_row_index_table; drives the item, result and
// register ports and checks every result against a built-in table model or a listed result.
module tb_top;
	import sri_pkg::*;

	// Generous wall for a hung run.
	localparam int unsigned TIMEOUT = 20_000_000;

	typedef struct packed {
		in_item_t  stim;
		logic      typed;
		out_item_t res;
	} directed_row_t;

	// Directed opening, run with 3 rows of 64 columns. Rows with typed set carry
	// their result; the rest go through the table model.
	localparam directed_row_t DIRECTED [24] = '{
		// queries on an empty table: incomplete
		'{'{CMD_LOOKUP,   6'd0,  6'd0,  64'd0},  1'b1, '{STAT_INCOMPLETE, 12'd0, 6'd0, 1'b1}},
		'{'{CMD_LIST_ROW, 6'd0,  6'd0,  64'd0},  1'b1, '{STAT_INCOMPLETE, 12'd0, 6'd0, 1'b1}},
		'{'{CMD_LIST_COL, 6'd0,  6'd63, 64'd0},  1'b1, '{STAT_INCOMPLETE, 12'd0, 6'd0, 1'b1}},
		// row 1 before row 0: out of order
		'{'{CMD_LOAD,     6'd1,  6'd0,  64'd0},  1'b1, '{STAT_LOAD_ORDER, 12'd0, 6'd0, 1'b1}},
		// full row, then a skipped row, then an empty row
		'{'{CMD_LOAD,     6'd0,  6'd0,  '1},     1'b1, '{STAT_OK,         12'd64, 6'd0, 1'b1}},
		'{'{CMD_LOAD,     6'd2,  6'd0,  '1},     1'b1, '{STAT_LOAD_ORDER, 12'd0, 6'd0, 1'b1}},
		'{'{CMD_LOAD,     6'd1,  6'd63, 64'd0},  1'b1, '{STAT_OK,         12'd0, 6'd1, 1'b1}},
		'{'{CMD_LOOKUP,   6'd1,  6'd5,  64'd0},  1'b1, '{STAT_INCOMPLETE, 12'd0, 6'd0, 1'b1}},
		// outermost columns only; completes the table
		'{'{CMD_LOAD,     6'd2,  6'd0,  64'h8000_0000_0000_0001},
			1'b1, '{STAT_OK, 12'd2, 6'd2, 1'b1}},
		// one row too many
		'{'{CMD_LOAD,     6'd3,  6'd0,  '1},     1'b1, '{STAT_LOAD_ORDER, 12'd0, 6'd0, 1'b1}},
		'{'{CMD_LOOKUP,   6'd0,  6'd0,  '1},     1'b1, '{STAT_OK,         12'd0, 6'd0, 1'b1}},
		'{'{CMD_LOOKUP,   6'd0,  6'd63, 64'd0},  1'b1, '{STAT_OK,         12'd63, 6'd63, 1'b1}},
		'{'{CMD_LOOKUP,   6'd1,  6'd5,  64'd0},  1'b1, '{STAT_NOT_FOUND,  12'd0, 6'd0, 1'b1}},
		'{'{CMD_LOOKUP,   6'd2,  6'd63, 64'd0},  1'b1, '{STAT_OK,         12'd65, 6'd63, 1'b1}},
		'{'{CMD_LOOKUP,   6'd2,  6'd30, 64'd0},  1'b1, '{STAT_NOT_FOUND,  12'd0, 6'd0, 1'b1}},
		// rows beyond the built table
		'{'{CMD_LOOKUP,   6'd3,  6'd0,  64'd0},  1'b1, '{STAT_NOT_FOUND,  12'd0, 6'd0, 1'b1}},
		'{'{CMD_LOOKUP,   6'd63, 6'd63, '1},     1'b1, '{STAT_NOT_FOUND,  12'd0, 6'd0, 1'b1}},
		'{'{CMD_LIST_ROW, 6'd0,  6'd0,  64'd0},  1'b0, '0},
		'{'{CMD_LIST_ROW, 6'd1,  6'd0,  64'd0},  1'b1, '{STAT_NOT_FOUND,  12'd0, 6'd0, 1'b1}},
		'{'{CMD_LIST_ROW, 6'd2,  6'd0,  64'd0},  1'b0, '0},
		'{'{CMD_LIST_ROW, 6'd5,  6'd0,  64'd0},  1'b1, '{STAT_NOT_FOUND,  12'd0, 6'd0, 1'b1}},
		'{'{CMD_LIST_COL, 6'd0,  6'd0,  64'd0},  1'b0, '0},
		'{'{CMD_LIST_COL, 6'd0,  6'd63, 64'd0},  1'b0, '0},
		'{'{CMD_LIST_COL, 6'd63, 6'd31, 64'd0},  1'b0, '0}
	};

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	in_item_t         in_data   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_item_t        out_data;
	logic             cfg_we    = 1'b0;
	reg_index_t       cfg_index = REG_NUM_ROWS;
	logic [CFG_W-1:0] cfg_data  = '0;

	// Idle and stall chances in percent, changed as the run moves on.
	int send_gap_pct = 0;
	int stall_pct    = 0;
	int fault_count  = 0;

	// Table model: row offsets, stored columns, build progress and registers.
	logic [FILL_W-1:0] row_offset [0:MAX_ROWS];
	logic [COL_W-1:0]  entry_col  [0:MAX_ENTRIES-1];
	int unsigned       entries_stored = 0;
	int unsigned       rows_loaded    = 0;
	bit                table_ready    = 1'b0;
	logic [CFG_W-1:0]  cfg_rows       = 7'd64;
	logic [CFG_W-1:0]  cfg_cols       = 7'd64;

	out_item_t expected_results [$];
	out_item_t predicted [$];

	sparse_row_index_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Register values outside 1..hi are read as the nearest bound.
	function automatic int unsigned clamp_count(input logic [CFG_W-1:0] v, input int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic out_item_t make_result(input status_t s, input int unsigned idx,
			input int unsigned pos, input logic fin);
		out_item_t o;
		o.status      = s;
		o.entry_index = idx[IDX_W-1:0];
		o.position    = pos[5:0];
		o.last        = fin;
		return o;
	endfunction

	// Binary search of one built row; -1 when the column is absent. Bail out
	// early once the column falls outside the window's end columns.
	function automatic int search_row(input int r, input int c);
		int lo, hi, mid;
		lo = int'(row_offset[r]);
		hi = int'(row_offset[r + 1]) - 1;
		while (lo <= hi) begin
			if (c < int'(entry_col[lo]) || c > int'(entry_col[hi]))
				return -1;
			mid = (lo + hi) / 2;
			if (c < int'(entry_col[mid]))
				hi = mid - 1;
			else if (c > int'(entry_col[mid]))
				lo = mid + 1;
			else
				return mid;
		end
		return -1;
	endfunction

	// Work out the results of one item into predicted, updating the table.
	function automatic void predict_item(input in_item_t it);
		int unsigned rows, cols, first, r, c, i;
		int j, hit;
		out_item_t tail;
		predicted.delete();
		rows = clamp_count(cfg_rows, MAX_ROWS);
		cols = clamp_count(cfg_cols, MAX_COLS);
		r = it.row;
		c = it.col;
		if (it.cmd == CMD_LOAD) begin
			// row 0 always restarts the build, even when it then fails the order check
			if (r == 0) begin
				entries_stored = 0;
				rows_loaded = 0;
				table_ready = 1'b0;
			end
			if (r != rows_loaded || rows_loaded >= rows) begin
				predicted.push_back(make_result(STAT_LOAD_ORDER, 0, 0, 1'b1));
				return;
			end
			first = entries_stored;
			row_offset[r] = entries_stored[FILL_W-1:0];
			for (j = 0; j < cols; j++) begin
				if (it.row_bits[j] && entries_stored < MAX_ENTRIES) begin
					entry_col[entries_stored] = j[COL_W-1:0];
					entries_stored++;
				end
			end
			rows_loaded = r + 1;
			row_offset[rows_loaded] = entries_stored[FILL_W-1:0];
			if (rows_loaded == rows)
				table_ready = 1'b1;
			predicted.push_back(make_result(STAT_OK, entries_stored - first, r, 1'b1));
			return;
		end
		if (!table_ready) begin
			predicted.push_back(make_result(STAT_INCOMPLETE, 0, 0, 1'b1));
			return;
		end
		case (it.cmd)
			CMD_LOOKUP: begin
				hit = (r < rows_loaded) ? search_row(r, c) : -1;
				if (hit < 0)
					predicted.push_back(make_result(STAT_NOT_FOUND, 0, 0, 1'b1));
				else
					predicted.push_back(make_result(STAT_OK, hit, c, 1'b1));
				return;
			end
			CMD_LIST_ROW: begin
				if (r < rows_loaded) begin
					for (j = row_offset[r]; j < int'(row_offset[r + 1]) && predicted.size() < 64;
							j++)
						predicted.push_back(make_result(STAT_OK, j, entry_col[j], 1'b0));
				end
			end
			default: begin
				for (i = 0; i < rows_loaded && predicted.size() < 64; i++) begin
					hit = search_row(i, c);
					if (hit >= 0)
						predicted.push_back(make_result(STAT_OK, hit, i, 1'b0));
				end
			end
		endcase
		// an empty list still answers once
		if (predicted.size() == 0) begin
			predicted.push_back(make_result(STAT_NOT_FOUND, 0, 0, 1'b1));
		end else begin
			tail = predicted.pop_back();
			tail.last = 1'b1;
			predicted.push_back(tail);
		end
	endfunction

	// Mask rows from empty through sparse and dense to full.
	function automatic logic [63:0] mask_word();
		logic [63:0] w;
		case ($urandom_range(5))
			0: w = '1;
			1: w = '0;
			2: w = {$urandom, $urandom};
			3: w = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			4: w = {$urandom, $urandom} | {$urandom, $urandom};
			default: w = 64'd1 << $urandom_range(63);
		endcase
		return w;
	endfunction

	// Query aimed mostly at rows inside the configured count and often at stored columns.
	function automatic in_item_t query_item();
		in_item_t q;
		int unsigned span;
		q.row_bits = {$urandom, $urandom};
		case ($urandom_range(2))
			0: q.cmd = CMD_LOOKUP;
			1: q.cmd = CMD_LIST_ROW;
			default: q.cmd = CMD_LIST_COL;
		endcase
		if ($urandom_range(99) < 80)
			q.row = $urandom_range(clamp_count(cfg_rows, MAX_ROWS) - 1);
		else
			q.row = $urandom_range(63);
		if (q.row < rows_loaded && row_offset[q.row + 1] != row_offset[q.row]
				&& $urandom_range(99) < 60) begin
			span = row_offset[q.row + 1] - row_offset[q.row];
			q.col = entry_col[row_offset[q.row] + $urandom_range(span - 1)];
		end else begin
			q.col = $urandom_range(63);
		end
		return q;
	endfunction

	// Load of any row but the next one; never row 0, which would restart.
	function automatic in_item_t stray_load();
		in_item_t s;
		int unsigned r;
		r = $urandom_range(1, 63);
		if (r == rows_loaded)
			r = r % 63 + 1;
		s.cmd = CMD_LOAD;
		s.row = r[ROW_W-1:0];
		s.col = $urandom_range(63);
		s.row_bits = mask_word();
		return s;
	endfunction

	// Offer one item, hold it until the transfer, then queue what it should
	// produce. Valid stays high afterwards so back-to-back items need no
	// second assignment in the same step.
	task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_item(it);
		if (typed)
			expected_results.push_back(typed_res);
		else
			foreach (predicted[k])
				expected_results.push_back(predicted[k]);
	endtask

	// Drop valid and wait until every expected result has arrived, then wait on
	// for the block to fall back to idle.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write both registers, rows first and then columns, with the block idle.
	task automatic write_config(input logic [CFG_W-1:0] rows_w, input logic [CFG_W-1:0] cols_w);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_NUM_ROWS;
		cfg_data <= rows_w;
		@(posedge clk);
		cfg_index <= REG_NUM_COLS;
		cfg_data <= cols_w;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_rows = rows_w;
		cfg_cols = cols_w;
	endtask

	// One setting: probe the old table under the new registers, build a new
	// one in order with stray items and perhaps a restart mixed in, then query.
	task automatic run_phase(input logic [CFG_W-1:0] rows_w, input logic [CFG_W-1:0] cols_w,
			input int loads, input int queries, input bit dense);
		int r;
		bit restarted;
		in_item_t it;
		write_config(rows_w, cols_w);
		repeat (2) send_item(query_item(), 1'b0, '0);
		r = 0;
		restarted = 1'b0;
		while (r < loads) begin
			if ($urandom_range(99) < 8)
				send_item($urandom_range(1) ? stray_load() : query_item(), 1'b0, '0);
			if (!restarted && r > 1 && $urandom_range(99) < 6) begin
				restarted = 1'b1;
				r = 0;
			end
			it.cmd = CMD_LOAD;
			it.row = r[ROW_W-1:0];
			it.col = $urandom_range(63);
			it.row_bits = dense ? '1 : mask_word();
			send_item(it, 1'b0, '0);
			r++;
		end
		repeat (queries)
			send_item(($urandom_range(99) < 8) ? stray_load() : query_item(), 1'b0, '0);
	endtask

	// Check each result transfer against the oldest expectation and set the
	// receiver stall for the next edge.
	always @(posedge clk) begin : check_results
		out_item_t want;
		out_stall <= ($urandom_range(99) < stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				if (fault_count < 10)
					$display("unexpected result: status %0d index %0d position %0d last %0d",
						out_data.status, out_data.entry_index, out_data.position,
						out_data.last);
				fault_count++;
			end else begin
				want = expected_results.pop_front();
				if (out_data.status !== want.status || out_data.entry_index !== want.entry_index
						|| out_data.position !== want.position || out_data.last !== want.last) begin
					if (fault_count < 10)
						$display("mismatch: expected status %0d index %0d position %0d last %0d,",
							want.status, want.entry_index, want.position, want.last,
							" got status %0d index %0d position %0d last %0d",
							out_data.status, out_data.entry_index, out_data.position,
							out_data.last);
					fault_count++;
				end
			end
		end
	end

	initial begin : stimulus
		int rr;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// sender mostly busy, receiver stalling hard
		send_gap_pct = 10;
		stall_pct = 67;
		write_config(7'd3, 7'd64);
		foreach (DIRECTED[k])
			send_item(DIRECTED[k].stim, DIRECTED[k].typed, DIRECTED[k].res);
		// largest table, every entry filled
		run_phase(7'd64, 7'd64, 64, 14, 1'b1);
		run_phase(7'd1, 7'd1, 1, 10, 1'b0);

		// swap the roles: sender gappy, receiver mostly ready
		send_gap_pct = 67;
		stall_pct = 10;
		// out-of-range register values clamp to the bounds
		run_phase(7'd0, 7'd127, 1, 10, 1'b0);
		run_phase(7'd6, 7'd13, 6, 10, 1'b0);
		rr = $urandom_range(2, 8);
		run_phase(rr[CFG_W-1:0], 7'($urandom_range(1, 64)), rr, 12, 1'b0);

		// no idling on either side
		send_gap_pct = 0;
		stall_pct = 0;
		// 64 rows wanted but only a few loaded: queries stay incomplete
		run_phase(7'd127, 7'd2, 8, 8, 1'b0);
		run_phase(7'd3, 7'd64, 3, 10, 1'b0);
		rr = $urandom_range(2, 8);
		run_phase(rr[CFG_W-1:0], 7'($urandom_range(1, 64)), rr, 12, 1'b0);

		settle();
		repeat (200) @(posedge clk);
		if (fault_count == 0 && expected_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT);
		$display("TB_ERROR");
		$finish;
	end

endmodule
